/* hw/rtl/twl_pkg.sv */
// Shared codes, types and defaults for the timed wait list.
package twl_pkg;

  localparam int DEPTH_DEFAULT     = 16;
  localparam int TICK_BITS_DEFAULT = 16;

  localparam int HANDLE_W = 16;
  localparam int WAIT_W   = 16;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  localparam logic [1:0] FN_ADD    = 2'd0;
  localparam logic [1:0] FN_REMOVE = 2'd1;
  localparam logic [1:0] FN_TICK   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REJECT   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd5;
  localparam logic [STATUS_W-1:0] ST_NONE     = 3'd6;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FIN
  } twl_state_t;

endpackage

/* hw/rtl/timed_wait_list_top.sv */
// Timed wait list: ordered list of thread handles with tick countdowns.
//
// An item is taken when start is high and busy is low. Add, rejected
// commands, an out-of-range remove and a tick on an empty list never
// raise busy: the result strobes on the next cycle. A remove at p keeps
// busy while the walk runs from entry p to the last entry and then
// through the finish state, a tick likewise from entry 0: the walk reads
// one entry and writes back one survivor per cycle on the entry RAM.
// Each result is shown for one cycle with valid high and cannot be held
// off; releases of one tick may strobe on consecutive cycles, oldest
// first, and the final result of every item carries last.
module timed_wait_list_top #(
  parameter int DEPTH     = twl_pkg::DEPTH_DEFAULT,
  parameter int TICK_BITS = twl_pkg::TICK_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    func,
  input  logic [twl_pkg::HANDLE_W-1:0]  thread_handle,
  input  logic [twl_pkg::WAIT_W-1:0]    wait_ticks,
  input  logic [twl_pkg::POS_W-1:0]     position,
  output logic                          valid,
  output logic [twl_pkg::STATUS_W-1:0]  status,
  output logic [twl_pkg::HANDLE_W-1:0]  released_handle,
  output logic [twl_pkg::COUNT_W-1:0]   entry_count,
  output logic                          last
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DW    = twl_pkg::HANDLE_W + TICK_BITS;
  localparam logic [TICK_BITS-1:0] TMAX = {TICK_BITS{1'b1}};

  twl_pkg::twl_state_t state, state_next;

  logic [CNT_W-1:0] occupancy, occupancy_next;
  logic [CNT_W-1:0] didx, didx_next;       // index of entry whose data is arriving
  logic [CNT_W-1:0] wptr, wptr_next;       // compaction write index
  logic [CNT_W-1:0] live, live_next;       // entries left as the walk drops them
  logic             mode_tick, mode_tick_next;
  logic [CNT_W-1:0] pos_q, pos_q_next;
  logic                         pend_valid, pend_valid_next;
  logic [twl_pkg::HANDLE_W-1:0] pend_handle, pend_handle_next;
  logic [CNT_W-1:0]             pend_count, pend_count_next;

  logic                         valid_next;
  logic [twl_pkg::STATUS_W-1:0] status_next;
  logic [twl_pkg::HANDLE_W-1:0] released_handle_next;
  logic [twl_pkg::COUNT_W-1:0]  entry_count_next;
  logic                         last_next;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0]    ram_wdata, ram_rdata;

  logic [twl_pkg::HANDLE_W-1:0] rd_handle;
  logic [TICK_BITS-1:0]         rd_count, dec_count;
  logic [TICK_BITS-1:0]         add_count;
  logic                         accept, drop;

  twl_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy      = (state != twl_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign rd_handle = ram_rdata[DW-1 -: twl_pkg::HANDLE_W];
  assign rd_count  = ram_rdata[TICK_BITS-1:0];
  assign dec_count = (rd_count != '0) ? rd_count - TICK_BITS'(1) : '0;
  assign drop      = mode_tick ? (dec_count == '0) : (didx == pos_q);
  assign add_count = (32'(wait_ticks) > 32'(TMAX)) ? TMAX : TICK_BITS'(wait_ticks);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= twl_pkg::S_IDLE;
      occupancy  <= '0;
      pend_valid <= 1'b0;
      valid      <= 1'b0;
    end else begin
      state      <= state_next;
      occupancy  <= occupancy_next;
      pend_valid <= pend_valid_next;
      valid      <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    didx            <= didx_next;
    wptr            <= wptr_next;
    live            <= live_next;
    mode_tick       <= mode_tick_next;
    pos_q           <= pos_q_next;
    pend_handle     <= pend_handle_next;
    pend_count      <= pend_count_next;
    status          <= status_next;
    released_handle <= released_handle_next;
    entry_count     <= entry_count_next;
    last            <= last_next;
  end

  always_comb begin
    state_next           = state;
    occupancy_next       = occupancy;
    didx_next            = didx;
    wptr_next            = wptr;
    live_next            = live;
    mode_tick_next       = mode_tick;
    pos_q_next           = pos_q;
    pend_valid_next      = pend_valid;
    pend_handle_next     = pend_handle;
    pend_count_next      = pend_count;
    valid_next           = 1'b0;
    status_next          = status;
    released_handle_next = '0;
    entry_count_next     = entry_count;
    last_next            = 1'b1;
    ram_we               = 1'b0;
    ram_waddr            = IDX_W'(wptr);
    ram_wdata            = {rd_handle, mode_tick ? dec_count : rd_count};
    ram_raddr            = IDX_W'(didx + CNT_W'(1));

    unique case (state)
      twl_pkg::S_IDLE: begin
        ram_raddr = (func == twl_pkg::FN_REMOVE) ? IDX_W'(position) : '0;
        if (accept) begin
          valid_next       = 1'b1;
          entry_count_next = twl_pkg::COUNT_W'(occupancy);
          pend_valid_next  = 1'b0;
          live_next        = occupancy;
          case (func)
            twl_pkg::FN_ADD: begin
              if (thread_handle == '0 || wait_ticks == '0) begin
                status_next = twl_pkg::ST_REJECT;
              end else if (occupancy >= CNT_W'(DEPTH)) begin
                status_next = twl_pkg::ST_FULL;
              end else begin
                ram_we           = 1'b1;
                ram_waddr        = IDX_W'(occupancy);
                ram_wdata        = {thread_handle, add_count};
                occupancy_next   = occupancy + CNT_W'(1);
                status_next      = twl_pkg::ST_ADDED;
                entry_count_next = twl_pkg::COUNT_W'(occupancy + CNT_W'(1));
              end
            end
            twl_pkg::FN_REMOVE: begin
              if (32'(position) >= 32'(occupancy)) begin
                status_next = twl_pkg::ST_RANGE;
              end else begin
                valid_next     = 1'b0;
                mode_tick_next = 1'b0;
                pos_q_next     = CNT_W'(position);
                didx_next      = CNT_W'(position);
                wptr_next      = CNT_W'(position);
                state_next     = twl_pkg::S_WALK;
              end
            end
            twl_pkg::FN_TICK: begin
              if (occupancy == '0) begin
                status_next = twl_pkg::ST_NONE;
              end else begin
                valid_next     = 1'b0;
                mode_tick_next = 1'b1;
                didx_next      = '0;
                wptr_next      = '0;
                state_next     = twl_pkg::S_WALK;
              end
            end
            default: begin
              status_next = twl_pkg::ST_REJECT;
            end
          endcase
        end
      end

      twl_pkg::S_WALK: begin
        didx_next = didx + CNT_W'(1);
        if (didx == occupancy - CNT_W'(1)) begin
          state_next = twl_pkg::S_FIN;
        end
        if (!drop) begin
          ram_we    = 1'b1;
          wptr_next = wptr + CNT_W'(1);
        end else begin
          live_next        = live - CNT_W'(1);
          pend_valid_next  = 1'b1;
          pend_handle_next = rd_handle;
          pend_count_next  = live - CNT_W'(1);
          // a new release pushes out the one held back, which is not the last
          if (mode_tick && pend_valid) begin
            valid_next           = 1'b1;
            status_next          = twl_pkg::ST_RELEASED;
            released_handle_next = pend_handle;
            entry_count_next     = twl_pkg::COUNT_W'(pend_count);
            last_next            = 1'b0;
          end
        end
      end

      twl_pkg::S_FIN: begin
        occupancy_next   = wptr;
        valid_next       = 1'b1;
        entry_count_next = twl_pkg::COUNT_W'(wptr);
        pend_valid_next  = 1'b0;
        state_next       = twl_pkg::S_IDLE;
        if (!mode_tick) begin
          status_next          = twl_pkg::ST_REMOVED;
          released_handle_next = pend_handle;
        end else if (pend_valid) begin
          status_next          = twl_pkg::ST_RELEASED;
          released_handle_next = pend_handle;
          entry_count_next     = twl_pkg::COUNT_W'(pend_count);
        end else begin
          status_next = twl_pkg::ST_NONE;
        end
      end

      default: begin
        state_next = twl_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/twl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module twl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* tb/tb_timed_wait_list_top.sv */
// Testbench for the timed wait list: random and directed commands, checked by a scoreboard.
`timescale 1ns / 100ps

module tb_timed_wait_list_top;

  localparam int DEPTH       = twl_pkg::DEPTH_DEFAULT;
  localparam int TICK_BITS   = twl_pkg::TICK_BITS_DEFAULT;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_BEATS = 320;
  localparam logic [1:0] FN_UNUSED = 2'd3;

  typedef struct {
    logic [twl_pkg::STATUS_W-1:0] status;
    logic [twl_pkg::HANDLE_W-1:0] handle;
    logic [twl_pkg::COUNT_W-1:0]  count;
    logic                         last;
  } wait_result_t;

  // Scoreboard: its own copy of the list, and the results still owed by the block.
  class wait_list_scoreboard;
    logic [twl_pkg::HANDLE_W-1:0] handles[$];
    logic [31:0]                  countdowns[$];
    wait_result_t                 owed_q[$];
    int                           errors = 0;

    function void owe(logic [twl_pkg::STATUS_W-1:0] st, logic [twl_pkg::HANDLE_W-1:0] h,
                      int cnt, logic l);
      wait_result_t r;
      r.status = st;
      r.handle = h;
      r.count  = cnt[twl_pkg::COUNT_W-1:0];
      r.last   = l;
      owed_q.push_back(r);
    endfunction

    function void note_item(logic [1:0] f, logic [twl_pkg::HANDLE_W-1:0] h,
                            logic [twl_pkg::WAIT_W-1:0] w, logic [twl_pkg::POS_W-1:0] p);
      logic [31:0]                  tmax;
      logic [31:0]                  c;
      logic [twl_pkg::HANDLE_W-1:0] kept_h[$];
      logic [31:0]                  kept_c[$];
      logic [twl_pkg::HANDLE_W-1:0] taken;
      wait_result_t                 r;
      int                           cnt;
      int                           released;
      tmax = (TICK_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << TICK_BITS) - 32'd1);
      case (f)
        twl_pkg::FN_ADD: begin
          if (h == '0 || w == '0) begin
            owe(twl_pkg::ST_REJECT, '0, handles.size(), 1'b1);
          end else if (handles.size() >= DEPTH) begin
            owe(twl_pkg::ST_FULL, '0, handles.size(), 1'b1);
          end else begin
            c = (32'(w) > tmax) ? tmax : 32'(w);
            handles.push_back(h);
            countdowns.push_back(c);
            owe(twl_pkg::ST_ADDED, '0, handles.size(), 1'b1);
          end
        end
        twl_pkg::FN_REMOVE: begin
          if (int'(p) >= handles.size()) begin
            owe(twl_pkg::ST_RANGE, '0, handles.size(), 1'b1);
          end else begin
            taken = handles[p];
            handles.delete(p);
            countdowns.delete(p);
            owe(twl_pkg::ST_REMOVED, taken, handles.size(), 1'b1);
          end
        end
        twl_pkg::FN_TICK: begin
          cnt = handles.size();
          released = 0;
          for (int i = 0; i < cnt; i++) begin
            c = countdowns[i];
            if (c != 0) c = c - 1;
            if (c == 0) begin
              released++;
              owe(twl_pkg::ST_RELEASED, handles[i], cnt - released, 1'b0);
            end else begin
              kept_h.push_back(handles[i]);
              kept_c.push_back(c);
            end
          end
          handles = kept_h;
          countdowns = kept_c;
          if (released == 0) begin
            owe(twl_pkg::ST_NONE, '0, handles.size(), 1'b1);
          end else begin
            r = owed_q.pop_back();
            r.last = 1'b1;
            owed_q.push_back(r);
          end
        end
        default: owe(twl_pkg::ST_REJECT, '0, handles.size(), 1'b1);
      endcase
    endfunction

    function void check_result(logic [twl_pkg::STATUS_W-1:0] st,
                               logic [twl_pkg::HANDLE_W-1:0] h,
                               logic [twl_pkg::COUNT_W-1:0] cnt, logic l);
      wait_result_t e;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result status %0d handle %h count %0d last %b",
                 $time, st, h, cnt, l);
        errors++;
      end else begin
        e = owed_q.pop_front();
        if (st !== e.status || h !== e.handle || cnt !== e.count || l !== e.last) begin
          $display("%0t: mismatch expected status %0d handle %h count %0d last %b,",
                   $time, e.status, e.handle, e.count, e.last);
          $display("%0t:          actual   status %0d handle %h count %0d last %b",
                   $time, st, h, cnt, l);
          errors++;
        end
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic [1:0]                   func = twl_pkg::FN_ADD;
  logic [twl_pkg::HANDLE_W-1:0] thread_handle = '0;
  logic [twl_pkg::WAIT_W-1:0]   wait_ticks = '0;
  logic [twl_pkg::POS_W-1:0]    position = '0;
  logic                         busy;
  logic                         valid;
  logic [twl_pkg::STATUS_W-1:0] status;
  logic [twl_pkg::HANDLE_W-1:0] released_handle;
  logic [twl_pkg::COUNT_W-1:0]  entry_count;
  logic                         last;

  wait_list_scoreboard sb = new();
  int  cycles = 0;
  bit  idling_on = 1'b1;

  timed_wait_list_top #(.DEPTH(DEPTH), .TICK_BITS(TICK_BITS)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .thread_handle(thread_handle), .wait_ticks(wait_ticks), .position(position),
    .valid(valid), .status(status), .released_handle(released_handle),
    .entry_count(entry_count), .last(last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Results are checked before the beat of the same edge is noted.
  always @(posedge clk) begin
    if (!rst) begin
      if (valid) sb.check_result(status, released_handle, entry_count, last);
      if (start && !busy) sb.note_item(func, thread_handle, wait_ticks, position);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Drive one beat and hold it until taken; may drop start for a while afterwards.
  task automatic issue(logic [1:0] f, logic [twl_pkg::HANDLE_W-1:0] h,
                       logic [twl_pkg::WAIT_W-1:0] w, logic [twl_pkg::POS_W-1:0] p);
    start         <= 1'b1;
    func          <= f;
    thread_handle <= h;
    wait_ticks    <= w;
    position      <= p;
    do @(posedge clk); while (busy);
    while (idling_on && $urandom_range(99) < 37) begin
      start         <= 1'b0;
      func          <= 2'($urandom);
      thread_handle <= 16'($urandom);
      wait_ticks    <= 16'($urandom);
      position      <= 4'($urandom);
      @(posedge clk);
    end
  endtask

  task automatic random_beat();
    int                           occ;
    int                           pick;
    int                           add_pct;
    logic [twl_pkg::HANDLE_W-1:0] h;
    logic [twl_pkg::WAIT_W-1:0]   w;
    logic [twl_pkg::POS_W-1:0]    p;
    occ = sb.handles.size();
    pick = $urandom_range(99);
    add_pct = (occ < 12) ? 55 : 40;
    h = 16'($urandom_range(1, 65535));
    case ($urandom_range(9))
      0:       w = 16'($urandom_range(0, 65535));
      1, 2:    w = 16'($urandom_range(1, 40));
      default: w = 16'($urandom_range(1, 6));
    endcase
    if (pick < add_pct) begin
      // A few malformed adds
      if ($urandom_range(99) < 10) begin
        if ($urandom_range(1)) h = '0;
        else w = '0;
      end
      issue(twl_pkg::FN_ADD, h, w, 4'($urandom));
    end else if (pick < add_pct + 22) begin
      if (occ > 0 && $urandom_range(99) < 80) p = 4'($urandom_range(0, occ - 1));
      else p = 4'($urandom);
      issue(twl_pkg::FN_REMOVE, 16'($urandom), 16'($urandom), p);
    end else if (pick < 97) begin
      issue(twl_pkg::FN_TICK, 16'($urandom), 16'($urandom), 4'($urandom));
    end else begin
      issue(FN_UNUSED, 16'($urandom), 16'($urandom), 4'($urandom));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty list, malformed commands, fill to full, removes at both ends, releases.
    issue(twl_pkg::FN_TICK, '0, '0, '0);
    issue(twl_pkg::FN_REMOVE, '0, '0, 4'hF);
    issue(twl_pkg::FN_ADD, '0, 16'h0005, '0);
    issue(twl_pkg::FN_ADD, 16'h1234, '0, '0);
    issue(FN_UNUSED, 16'hFFFF, 16'hFFFF, 4'hF);
    for (int i = 0; i < DEPTH; i++) begin
      if (i == 0) issue(twl_pkg::FN_ADD, 16'hFFFF, 16'hFFFF, '0);
      else if (i == 1) issue(twl_pkg::FN_ADD, 16'h0001, 16'h0001, '0);
      else issue(twl_pkg::FN_ADD, 16'(16'h1000 + i), 16'((i % 3) + 1), 4'(i));
    end
    issue(twl_pkg::FN_ADD, 16'h0002, 16'h0001, '0);
    issue(twl_pkg::FN_REMOVE, '0, '0, 4'hF);
    issue(twl_pkg::FN_REMOVE, '0, '0, 4'h0);
    issue(twl_pkg::FN_TICK, '0, '0, '0);
    issue(twl_pkg::FN_TICK, '0, '0, '0);
    issue(twl_pkg::FN_REMOVE, '0, '0, 4'hF);

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      idling_on = !(n >= 150 && n < 230);
      random_beat();
    end
    start <= 1'b0;

    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (DEPTH + 4) @(posedge clk);

    if (sb.owed_q.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, sb.owed_q.size());
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
